@@ rtl/core/lcadc_pkg.sv @@
// ----------------------------------------------------------------------------
// lcadc_pkg
// shared types and constants of the load cell adc reader
// ----------------------------------------------------------------------------
package lcadc_pkg;

    // command codes carried by each tick request
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_MEASURE = 2'd1;
    localparam logic [1:0] CMD_TARE    = 2'd2;

    // configuration register indexes
    localparam int          CFG_IDX_W          = 2;
    localparam int          CFG_DATA_W         = 17;
    localparam logic [1:0]  CFG_TIMEOUT_LIMIT  = 2'd0;
    localparam logic [1:0]  CFG_MEASURE_SAMPLES = 2'd1;
    localparam logic [1:0]  CFG_TARE_SAMPLES   = 2'd2;

    // register widths and reset values
    localparam int          TIMEOUT_W      = 17;
    localparam int          COUNT_W        = 8;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 17'd100000;
    localparam logic [COUNT_W-1:0]   MEASURE_RESET = 8'd3;
    localparam logic [COUNT_W-1:0]   TARE_RESET    = 8'd10;

    // result word and its saturation bounds
    localparam int WEIGHT_W = 25;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    // per-tick status from the frame sequencer
    typedef struct packed {
        logic sck_level;
        logic busy;
        logic timed_out;
        logic avg_req;
        logic tare_run;
    } t_tick_res;

endpackage

@@ rtl/core/lcadc_ifs.sv @@
// ----------------------------------------------------------------------------
// lcadc channel interfaces
// tick request channel, result channel and register write channel
// ----------------------------------------------------------------------------
interface lcadc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       dt_level;

    modport source (output valid, output cmd, output dt_level, input ready);
    modport sink   (input valid, input cmd, input dt_level, output ready);
endinterface

interface lcadc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 sck_level;
    logic                                 busy_res;
    logic                                 value_valid;
    logic signed [lcadc_pkg::WEIGHT_W-1:0] weight_value;
    logic                                 tare_done;
    logic                                 sample_timed_out;

    modport source (output valid, output sck_level, output busy_res, output value_valid,
                    output weight_value, output tare_done, output sample_timed_out,
                    input ready);
    modport sink   (input valid, input sck_level, input busy_res, input value_valid,
                    input weight_value, input tare_done, input sample_timed_out,
                    output ready);
endinterface

interface lcadc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lcadc_pkg::CFG_IDX_W-1:0]     index;
    logic [lcadc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/lcadc_divider.sv @@
// ----------------------------------------------------------------------------
// lcadc_divider
// bit-serial restoring divider, signed dividend by 8-bit count, truncating
// ----------------------------------------------------------------------------
module lcadc_divider #(
    parameter int DIVIDEND_W = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DIVIDEND_W-1:0] i_dividend,
    input  logic [lcadc_pkg::COUNT_W-1:0] i_divisor,
    output logic                         o_done,
    output logic signed [DIVIDEND_W-1:0] o_quotient
);
    import lcadc_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_RUN  = 2'd1;
    localparam logic [1:0] DV_FIX  = 2'd2;

    logic [1:0]            r_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [COUNT_W-1:0]    r_rem;
    logic [COUNT_W-1:0]    r_div;
    logic [DIVIDEND_W-1:0] r_quo;
    logic                  r_neg;
    logic                  r_done;
    logic [DIVIDEND_W-1:0] r_q_out;

    logic [COUNT_W:0]      trial;
    logic                  fits;

    // one quotient bit per cycle
    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == DV_FIX);
            unique case (r_state)
                DV_IDLE: begin
                    if (i_start) begin
                        r_state <= DV_RUN;
                    end
                end
                DV_RUN: begin
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= DV_FIX;
                    end
                end
                DV_FIX: begin
                    r_state <= DV_IDLE;
                end
                default: r_state <= DV_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == DV_IDLE && i_start) begin
            r_quo <= i_dividend[DIVIDEND_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_neg <= i_dividend[DIVIDEND_W-1];
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= CNT_W'(DIVIDEND_W);
        end else if (r_state == DV_RUN) begin
            r_rem <= fits ? COUNT_W'(trial - {1'b0, r_div}) : trial[COUNT_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
        end else if (r_state == DV_FIX) begin
            r_q_out <= r_neg ? (~r_quo + 1'b1) : r_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q_out;

endmodule

@@ rtl/core/lcadc_frame.sv @@
// ----------------------------------------------------------------------------
// lcadc_frame
// tick sequencer: data line wait, serial clock pulses, bit shift-in, summing
// ----------------------------------------------------------------------------
module lcadc_frame #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_tick,
    input  logic [1:0]                        i_cmd,
    input  logic                              i_dt_level,
    input  logic [lcadc_pkg::TIMEOUT_W-1:0]   i_timeout_limit,
    input  logic [lcadc_pkg::COUNT_W-1:0]     i_measure_samples,
    input  logic [lcadc_pkg::COUNT_W-1:0]     i_tare_samples,
    output lcadc_pkg::t_tick_res              o_res,
    output logic signed [SAMPLE_BITS+7:0]     o_sum,
    output logic [lcadc_pkg::COUNT_W-1:0]     o_divisor
);
    import lcadc_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + 8;
    localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_WAIT    = 3'd1;
    localparam logic [2:0] PH_BIT_HI  = 3'd2;
    localparam logic [2:0] PH_BIT_LO  = 3'd3;
    localparam logic [2:0] PH_GAIN_HI = 3'd4;
    localparam logic [2:0] PH_GAIN_LO = 3'd5;

    logic [2:0]             r_phase,   n_phase;
    logic [CNT_W-1:0]       r_bit_cnt, n_bit_cnt;
    logic [SAMPLE_BITS-1:0] r_shift,   n_shift;
    logic [TIMEOUT_W-1:0]   r_wait,    n_wait;
    logic [SUM_W-1:0]       r_sum,     n_sum;
    logic [COUNT_W-1:0]     r_taken,   n_taken;
    logic                   r_tare,    n_tare;

    logic [COUNT_W-1:0]     cfg_count;
    logic [COUNT_W-1:0]     div_count;
    logic                   fin;
    logic [SUM_W-1:0]       fin_sample;
    t_tick_res              res;

    assign cfg_count = r_tare ? i_tare_samples : i_measure_samples;
    assign div_count = (cfg_count == '0) ? COUNT_W'(1) : cfg_count;

    always_comb begin
        n_phase    = r_phase;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_wait     = r_wait;
        n_sum      = r_sum;
        n_taken    = r_taken;
        n_tare     = r_tare;
        fin        = 1'b0;
        fin_sample = '0;
        res        = '0;
        if (i_tick) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_cmd == CMD_MEASURE || i_cmd == CMD_TARE) begin
                        n_tare  = (i_cmd == CMD_TARE);
                        n_sum   = '0;
                        n_taken = '0;
                        n_wait  = i_timeout_limit;
                        n_phase = PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    if (!i_dt_level) begin
                        n_bit_cnt     = '0;
                        n_shift       = '0;
                        res.sck_level = 1'b1;
                        n_phase       = PH_BIT_HI;
                    end else begin
                        n_wait = r_wait - 1'b1;
                        if (n_wait == '0) begin
                            res.timed_out = 1'b1;
                            fin           = 1'b1;
                        end
                    end
                end
                PH_BIT_HI: n_phase = PH_BIT_LO;
                PH_BIT_LO: begin
                    // data bit valid while clock is low, msb first
                    n_shift       = {r_shift[SAMPLE_BITS-2:0], i_dt_level};
                    n_bit_cnt     = r_bit_cnt + 1'b1;
                    res.sck_level = 1'b1;
                    n_phase       = (n_bit_cnt >= CNT_W'(SAMPLE_BITS)) ? PH_GAIN_HI : PH_BIT_HI;
                end
                PH_GAIN_HI: n_phase = PH_GAIN_LO;
                PH_GAIN_LO: begin
                    fin        = 1'b1;
                    fin_sample = {{8{r_shift[SAMPLE_BITS-1]}}, r_shift};
                end
                default: n_phase = PH_IDLE;
            endcase

            if (fin) begin
                n_sum   = r_sum + fin_sample;
                n_taken = r_taken + 1'b1;
                if (n_taken >= div_count) begin
                    res.avg_req = 1'b1;
                    n_phase     = PH_IDLE;
                end else begin
                    n_wait  = i_timeout_limit;
                    n_phase = PH_WAIT;
                end
            end
        end
        res.busy     = (n_phase != PH_IDLE);
        res.tare_run = r_tare;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            r_wait    <= '0;
            r_sum     <= '0;
            r_taken   <= '0;
            r_tare    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_wait    <= n_wait;
            r_sum     <= n_sum;
            r_taken   <= n_taken;
            r_tare    <= n_tare;
        end
    end

    assign o_res     = res;
    assign o_sum     = r_sum;
    assign o_divisor = div_count;

endmodule

@@ rtl/core/load_cell_adc_reader.sv @@
// ----------------------------------------------------------------------------
// load_cell_adc_reader
// two-wire load cell converter reader with averaging and tare offset
// ----------------------------------------------------------------------------
// i_in carries one request per half-bit-period tick: a command (plain tick,
// start measurement, start tare) and the level seen on the converter data
// line. every request gives exactly one result on o_out: the serial clock
// level to drive until the next tick, a busy flag, and the strobes for a
// finished measurement, a stored tare offset or an expired data wait.
// i_cfg writes timeout_limit, measure_samples and tare_samples by index;
// it is always ready and is meant to be used while no run is in progress.
// an ordinary tick is answered from the result register in the cycle after
// it is taken, so ticks flow at one per cycle while results are drained. the
// tick that closes a run (last sample summed) goes through the serial
// divider: start, SAMPLE_BITS+8 quotient bits, sign fix-up and offset or
// saturation steps; no new tick is taken until its result is written.
// a stalled receiver holds the result register; a new tick is taken in the
// same cycle the held result leaves. reset returns the sequencer to idle,
// clears the tare offset and loads the register defaults; no result waits
// ----------------------------------------------------------------------------
module load_cell_adc_reader #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lcadc_in_if.sink      i_in,
    lcadc_out_if.source   o_out,
    lcadc_cfg_if.sink     i_cfg
);
    import lcadc_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + 8;
    localparam int DIFF_W = SUM_W + 1;

    // control sequence around the averaging divide
    localparam logic [1:0] ST_TICK     = 2'd0;
    localparam logic [1:0] ST_DIV_GO   = 2'd1;
    localparam logic [1:0] ST_DIV_WAIT = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    // configuration registers
    logic [TIMEOUT_W-1:0]   r_timeout_limit;
    logic [COUNT_W-1:0]     r_measure_samples;
    logic [COUNT_W-1:0]     r_tare_samples;

    logic [1:0]             r_state;
    logic [SAMPLE_BITS-1:0] r_offset;
    logic [DIFF_W-1:0]      r_diff;

    // status of the tick that closed a run, held across the divide
    logic                   r_pend_sck;
    logic                   r_pend_busy;
    logic                   r_pend_to;

    // result register
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_sck;
    logic                   r_out_busy;
    logic                   r_out_vv;
    logic [WEIGHT_W-1:0]    r_out_weight;
    logic                   r_out_td;
    logic                   r_out_to;

    logic                   tick;
    t_tick_res              res;
    logic signed [SUM_W-1:0] frame_sum;
    logic [COUNT_W-1:0]     frame_div;
    logic                   div_done;
    logic signed [SUM_W-1:0] quotient;
    logic [DIFF_W-WEIGHT_W:0] diff_top;
    logic [WEIGHT_W-1:0]    sat_weight;

    // a request is taken only when the result slot is free or freeing
    assign i_in.ready = (r_state == ST_TICK) && (!r_out_valid || o_out.ready);
    assign tick       = i_in.valid && i_in.ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit   <= TIMEOUT_RESET;
            r_measure_samples <= MEASURE_RESET;
            r_tare_samples    <= TARE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TIMEOUT_LIMIT:   r_timeout_limit   <= i_cfg.data[TIMEOUT_W-1:0];
                CFG_MEASURE_SAMPLES: r_measure_samples <= i_cfg.data[COUNT_W-1:0];
                CFG_TARE_SAMPLES:    r_tare_samples    <= i_cfg.data[COUNT_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    lcadc_frame #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_frame (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tick            (tick),
        .i_cmd             (i_in.cmd),
        .i_dt_level        (i_in.dt_level),
        .i_timeout_limit   (r_timeout_limit),
        .i_measure_samples (r_measure_samples),
        .i_tare_samples    (r_tare_samples),
        .o_res             (res),
        .o_sum             (frame_sum),
        .o_divisor         (frame_div)
    );

    // sum is registered in the frame, so the divide starts in the cycle after the closing tick
    lcadc_divider #(
        .DIVIDEND_W (SUM_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DIV_GO),
        .i_dividend (frame_sum),
        .i_divisor  (frame_div),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // clamp the average minus offset into the result word
    assign diff_top = r_diff[DIFF_W-1:WEIGHT_W-1];
    always_comb begin
        if (diff_top == '0 || diff_top == '1) begin
            sat_weight = r_diff[WEIGHT_W-1:0];
        end else if (r_diff[DIFF_W-1]) begin
            sat_weight = WEIGHT_MIN;
        end else begin
            sat_weight = WEIGHT_MAX;
        end
    end

    // result slot: a held result leaves when taken, a new one fills it
    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        if (r_state == ST_TICK && tick && !res.avg_req) begin
            n_out_valid = 1'b1;
        end
        if (r_state == ST_DIV_WAIT && div_done && res.tare_run) begin
            n_out_valid = 1'b1;
        end
        if (r_state == ST_SAT) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_TICK;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                ST_TICK: begin
                    if (tick && res.avg_req) begin
                        // closing tick: hold its status until the average is known
                        r_state <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO: r_state <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        if (res.tare_run) begin
                            r_offset <= quotient[SAMPLE_BITS-1:0];
                            r_state  <= ST_TICK;
                        end else begin
                            r_state <= ST_SAT;
                        end
                    end
                end
                ST_SAT: begin
                    r_state <= ST_TICK;
                end
                default: r_state <= ST_TICK;
            endcase
        end
    end

    // payload side of the result register and the held status
    always_ff @(posedge i_clk) begin
        if (r_state == ST_TICK && tick) begin
            r_pend_sck  <= res.sck_level;
            r_pend_busy <= res.busy;
            r_pend_to   <= res.timed_out;
            if (!res.avg_req) begin
                r_out_sck    <= res.sck_level;
                r_out_busy   <= res.busy;
                r_out_vv     <= 1'b0;
                r_out_weight <= '0;
                r_out_td     <= 1'b0;
                r_out_to     <= res.timed_out;
            end
        end
        if (r_state == ST_DIV_WAIT && div_done) begin
            r_diff <= {{(DIFF_W-SUM_W){quotient[SUM_W-1]}}, quotient}
                    - {{(DIFF_W-SAMPLE_BITS){r_offset[SAMPLE_BITS-1]}}, r_offset};
            if (res.tare_run) begin
                r_out_sck    <= r_pend_sck;
                r_out_busy   <= r_pend_busy;
                r_out_vv     <= 1'b0;
                r_out_weight <= '0;
                r_out_td     <= 1'b1;
                r_out_to     <= r_pend_to;
            end
        end
        if (r_state == ST_SAT) begin
            r_out_sck    <= r_pend_sck;
            r_out_busy   <= r_pend_busy;
            r_out_vv     <= 1'b1;
            r_out_weight <= sat_weight;
            r_out_td     <= 1'b0;
            r_out_to     <= r_pend_to;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.sck_level        = r_out_sck;
    assign o_out.busy_res         = r_out_busy;
    assign o_out.value_valid      = r_out_vv;
    assign o_out.weight_value     = r_out_weight;
    assign o_out.tare_done        = r_out_td;
    assign o_out.sample_timed_out = r_out_to;

endmodule
